@@ rtl/core/m4i_pkg.sv @@
`default_nettype none
package m4i_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_A0,
    ST_A1,
    ST_M1,
    ST_W1,
    ST_M2,
    ST_W2,
    ST_DRD,
    ST_DM,
    ST_DW,
    ST_VRD,
    ST_VST,
    ST_VW,
    ST_OUT
  } state_t;

  localparam logic [2:0] LAST_PERM = 3'd5;

  // row or column of a 3x3 minor mapped back onto the 4x4 matrix
  function automatic logic [1:0] skip_idx(logic [1:0] drop, logic [1:0] i);
    return (i >= drop) ? i + 2'd1 : i;
  endfunction

  // column picked in minor row i by permutation p, column fields from the lowest bits up
  function automatic logic [1:0] perm_col(logic [2:0] p, logic [1:0] i);
    logic [5:0] pc;
    unique case (p)
      3'd0:    pc = 6'b10_01_00;
      3'd1:    pc = 6'b01_10_00;
      3'd2:    pc = 6'b10_00_01;
      3'd3:    pc = 6'b00_10_01;
      3'd4:    pc = 6'b01_00_10;
      default: pc = 6'b00_01_10;
    endcase
    return pc[2*i +: 2];
  endfunction

  function automatic logic perm_odd(logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // store address of factor i of term p in the cofactor of position k
  function automatic logic [3:0] entry_addr(logic [3:0] k, logic [2:0] p, logic [1:0] i);
    return {skip_idx(k[3:2], i), skip_idx(k[1:0], perm_col(p, i))};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/m4i_ram.sv @@
`default_nettype none
module m4i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/m4i_mul.sv @@
`default_nettype none
// bit-serial signed multiplier, one multiplier bit per cycle
module m4i_mul #(
  parameter int A_WIDTH = 130,
  parameter int B_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_WIDTH-1:0] a,
  input  wire logic [B_WIDTH-1:0] b,
  output logic                    busy,
  output logic                    done,
  output logic      [A_WIDTH-1:0] prod
);

  localparam int CNTW = $clog2(B_WIDTH + 1);

  logic [A_WIDTH-1:0] mcand;
  logic [B_WIDTH-1:0] mplier;
  logic [CNTW-1:0]    cnt;
  logic               last_bit;

  assign last_bit = (cnt == CNTW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last_bit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(B_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // the sign bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (mplier[0]) begin
        prod <= last_bit ? prod - mcand : prod + mcand;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/m4i_div.sv @@
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module m4i_div #(
  parameter int NUM_WIDTH = 196,
  parameter int DEN_WIDTH = 131
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NUM_WIDTH-1:0] num,
  input  wire logic [DEN_WIDTH-1:0] den,
  output logic                      done,
  output logic      [NUM_WIDTH-1:0] quo
);

  localparam int CNTW = $clog2(NUM_WIDTH + 1);

  logic                 busy;
  logic [CNTW-1:0]      cnt;
  logic [NUM_WIDTH-1:0] nsh;
  logic [DEN_WIDTH-1:0] dreg;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH:0]   rem_sh;
  logic [DEN_WIDTH:0]   diff;
  logic                 ge;
  logic                 last_bit;

  assign rem_sh   = {rem, nsh[NUM_WIDTH-1]};
  assign diff     = rem_sh - {1'b0, dreg};
  assign ge       = !diff[DEN_WIDTH];
  assign last_bit = (cnt == CNTW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last_bit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= ge ? diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      quo <= {quo[NUM_WIDTH-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/matrix4_inverse_top.sv @@
`default_nettype none
// 4x4 matrix inverse, signed fixed point. Entries are written one per transfer into a
// 16-entry store by row-major index; the transfer with tlast set starts the inverse.
// All cofactors and the determinant are formed exactly with one bit-serial multiplier,
// then each of the 16 results comes from one bit-serial divider and is rounded to
// nearest (ties away from zero) and saturated. The input is not ready during a run.
// The run time is set by multiplier and divider iterations plus output stalls, with
// NW = max(3*VW+2*FB+1, 4*VW+1)+2 bits being the divider length. A singular matrix
// gives 16 zero results with the singular flag set.
module matrix4_inverse_top #(
  parameter int VALUE_WIDTH = m4i_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = m4i_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // entry_value, entry_index, zero pad
  input  wire logic [((VALUE_WIDTH+4+7)/8)*8-1:0]        s_tdata,
  // entry_last
  input  wire logic                                      s_tlast,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // result_value, result_index, zero pad
  output logic      [((VALUE_WIDTH+4+7)/8)*8-1:0]        m_tdata,
  // result_last
  output logic                                           m_tlast,
  // singular, saturated
  output logic      [1:0]                                m_tuser
);

  import m4i_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int TDW   = ((W + 4 + 7) / 8) * 8;
  localparam int CW    = 3 * W + 1;
  localparam int DW    = 4 * W + 2;
  localparam int NA    = 3 * W + 2 * FRAC_BITS + 1;
  localparam int NB    = 4 * W + 1;
  localparam int NW    = ((NA > NB) ? NA : NB) + 2;
  localparam int DENW  = DW + 1;
  localparam int SHIFT = 2 * FRAC_BITS + 1;

  state_t state, state_next;

  logic [3:0]    k, k_next;
  logic [2:0]    p, p_next;
  logic [DW-1:0] acc, acc_next;
  logic [DW-1:0] det, det_next;
  logic [DW-1:0] opa, opa_next;
  logic [DW-1:0] dmag, dmag_next;
  logic          dneg, dneg_next;
  logic          sing, sing_next;

  logic [W-1:0]  out_value, out_value_next;
  logic [3:0]    out_index, out_index_next;
  logic          out_last, out_last_next;
  logic          out_sing, out_sing_next;
  logic          out_sat, out_sat_next;

  logic          m_we;
  logic [3:0]    m_raddr;
  logic [W-1:0]  m_rdata;
  logic          c_we;
  logic [CW-1:0] c_rdata;

  logic          mul_start, mul_busy, mul_done;
  logic [W-1:0]  mul_b;
  logic [DW-1:0] mul_prod;

  logic            div_start, div_done;
  logic [NW-1:0]   div_num;
  logic [NW-1:0]   div_quo;

  logic [DW-1:0]   rd_ext;
  logic [DW-1:0]   acc_upd;
  logic            term_neg;
  logic [CW-1:0]   cmag;
  logic            nneg;
  logic            qneg;
  logic            over;
  logic [W-1:0]    lim_pos;
  logic [W-1:0]    lim_neg;

  assign rd_ext   = {{(DW-W){m_rdata[W-1]}}, m_rdata};
  assign term_neg = perm_odd(p) ^ k[2] ^ k[0];
  assign acc_upd  = term_neg ? acc - mul_prod : acc + mul_prod;
  assign nneg     = c_rdata[CW-1];
  assign cmag     = nneg ? -c_rdata : c_rdata;
  assign div_num  = ({{(NW-CW){1'b0}}, cmag} << SHIFT) + {{(NW-DW){1'b0}}, dmag};
  assign lim_pos  = {1'b0, {(W-1){1'b1}}};
  assign lim_neg  = {1'b1, {(W-1){1'b0}}};
  assign over     = (div_quo[NW-1:W] != '0) ||
                    (div_quo[W-1:0] > (qneg ? lim_neg : lim_pos));
  assign mul_b    = m_rdata;

  m4i_ram #(.WIDTH(W), .DEPTH(16)) u_mat (
    .clk   (clk),
    .we    (m_we),
    .waddr (s_tdata[W+3:W]),
    .wdata (s_tdata[W-1:0]),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // cofactors by position; read back transposed for the adjugate
  m4i_ram #(.WIDTH(CW), .DEPTH(16)) u_cof (
    .clk   (clk),
    .we    (c_we),
    .waddr (k),
    .wdata (acc_upd[CW-1:0]),
    .raddr ({k[1:0], k[3:2]}),
    .rdata (c_rdata)
  );

  m4i_mul #(.A_WIDTH(DW), .B_WIDTH(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  m4i_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DENW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({dmag, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    p         <= p_next;
    acc       <= acc_next;
    det       <= det_next;
    opa       <= opa_next;
    dmag      <= dmag_next;
    dneg      <= dneg_next;
    sing      <= sing_next;
    out_value <= out_value_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
    out_sing  <= out_sing_next;
    out_sat   <= out_sat_next;
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    p_next         = p;
    acc_next       = acc;
    det_next       = det;
    opa_next       = opa;
    dmag_next      = dmag;
    dneg_next      = dneg;
    sing_next      = sing;
    out_value_next = out_value;
    out_index_next = out_index;
    out_last_next  = out_last;
    out_sing_next  = out_sing;
    out_sat_next   = out_sat;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    m_we           = 1'b0;
    c_we           = 1'b0;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    qneg           = nneg ^ dneg;
    m_raddr        = k;

    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        m_we     = s_tvalid;
        if (s_tvalid && s_tlast) begin
          k_next     = '0;
          p_next     = '0;
          acc_next   = '0;
          det_next   = '0;
          state_next = ST_A0;
        end
      end
      ST_A0: begin
        m_raddr    = entry_addr(k, p, 2'd0);
        state_next = ST_A1;
      end
      ST_A1: begin
        m_raddr    = entry_addr(k, p, 2'd1);
        opa_next   = rd_ext;
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_start  = 1'b1;
        state_next = ST_W1;
      end
      ST_W1: begin
        m_raddr = entry_addr(k, p, 2'd2);
        if (mul_done) begin
          opa_next   = mul_prod;
          state_next = ST_M2;
        end
      end
      ST_M2: begin
        mul_start  = 1'b1;
        state_next = ST_W2;
      end
      ST_W2: begin
        if (mul_done) begin
          if (p != LAST_PERM) begin
            acc_next   = acc_upd;
            p_next     = p + 3'd1;
            state_next = ST_A0;
          end else begin
            c_we     = 1'b1;
            opa_next = acc_upd;
            if (k[3:2] == 2'd0) begin
              state_next = ST_DRD;
            end else if (k == 4'd15) begin
              k_next     = '0;
              sing_next  = (det == '0);
              dneg_next  = det[DW-1];
              dmag_next  = det[DW-1] ? -det : det;
              state_next = ST_VRD;
            end else begin
              k_next     = k + 4'd1;
              p_next     = '0;
              acc_next   = '0;
              state_next = ST_A0;
            end
          end
        end
      end
      ST_DRD: begin
        m_raddr    = {2'd0, k[1:0]};
        state_next = ST_DM;
      end
      ST_DM: begin
        mul_start  = 1'b1;
        state_next = ST_DW;
      end
      ST_DW: begin
        if (mul_done) begin
          det_next   = det + mul_prod;
          k_next     = k + 4'd1;
          p_next     = '0;
          acc_next   = '0;
          state_next = ST_A0;
        end
      end
      ST_VRD: begin
        if (sing) begin
          out_value_next = '0;
          out_index_next = k;
          out_last_next  = (k == 4'd15);
          out_sing_next  = 1'b1;
          out_sat_next   = 1'b0;
          state_next     = ST_OUT;
        end else begin
          state_next = ST_VST;
        end
      end
      ST_VST: begin
        div_start  = 1'b1;
        dneg_next  = dneg;
        opa_next   = {{(DW-1){1'b0}}, nneg};
        state_next = ST_VW;
      end
      ST_VW: begin
        // sign of the numerator was parked in opa at divider start
        qneg = opa[0] ^ dneg;
        if (div_done) begin
          if (over) begin
            out_value_next = qneg ? lim_neg : lim_pos;
          end else begin
            out_value_next = qneg ? -div_quo[W-1:0] : div_quo[W-1:0];
          end
          out_index_next = k;
          out_last_next  = (k == 4'd15);
          out_sing_next  = 1'b0;
          out_sat_next   = over;
          state_next     = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (k == 4'd15) begin
            state_next = ST_LOAD;
          end else begin
            k_next     = k + 4'd1;
            state_next = ST_VRD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign m_tdata = TDW'({out_index, out_value});
  assign m_tlast = out_last;
  assign m_tuser = {out_sat, out_sing};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input ready while a result is pending");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_sing |-> (out_value == '0) && !out_sat)
    else $error("singular result not zero");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_last == (out_index == 4'd15)))
    else $error("tlast not on the final result");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import m4i_pkg::*;

  localparam int VW = DEF_VALUE_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int DW = ((VW + 4 + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 260;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic [3:0]    index;
    logic          last;
    logic          singular;
    logic          saturated;
  } inv_entry_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          s_tlast = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic          m_tlast;
  logic [1:0]    m_tuser;

  matrix4_inverse_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  logic signed [VW-1:0] entry_mem [16];
  inv_entry_t           inverse_q [$];
  int error_count = 0;
  int entries_sent = 0;
  int inversions = 0;
  int singular_runs = 0;
  int saturated_results = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  // exact cofactor of (row, col), scale 2^(3*FB)
  function automatic wide_t cofactor_of(int row, int col);
    wide_t m [3][3];
    int rr [3];
    int cc [3];
    int n;
    wide_t c;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != row) begin rr[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != col) begin cc[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = entry_mem[rr[i] * 4 + cc[j]];
    c = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((row + col) % 2 == 1) ? -c : c;
  endfunction

  task automatic predict_inverse();
    wide_t cof [16];
    wide_t det;
    wide_t e;
    logic [255:0] dmag, tmag, num, q;
    logic dneg, neg, sat;
    inv_entry_t r;
    det = '0;
    for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k / 4, k % 4);
    for (int k = 0; k < 4; k++) begin
      e = entry_mem[k];
      det = det + e * cof[k];
    end
    inversions++;
    if (det == 0) singular_runs++;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r = '0;
      r.index = k[3:0];
      r.last = (k == 15);
      if (det == 0) begin
        r.singular = 1'b1;
      end else begin
        e = cof[(k % 4) * 4 + k / 4];
        tmag = (e < 0) ? -e : e;
        neg = (e < 0) != dneg;
        // round to nearest, ties away from zero, on the magnitude
        num = (tmag << (2 * FB + 1)) + dmag;
        q = num / (dmag << 1);
        sat = neg ? (q > (256'd1 << (VW - 1))) : (q > ((256'd1 << (VW - 1)) - 1));
        if (sat) q = neg ? (256'd1 << (VW - 1)) : ((256'd1 << (VW - 1)) - 1);
        r.value = neg ? -q[VW-1:0] : q[VW-1:0];
        r.saturated = sat;
        if (sat) saturated_results++;
      end
      inverse_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    error_count++;
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_entry(logic [VW-1:0] value, logic [3:0] index, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = '0;
    s_tdata[VW-1:0] = value;
    s_tdata[VW+3:VW] = index;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    entry_mem[index] = value;
    entries_sent++;
    if (last) predict_inverse();
  endtask

  task automatic send_matrix(logic [VW-1:0] vals [16]);
    for (int k = 0; k < 16; k++) send_entry(vals[k], k[3:0], k == 15);
  endtask

  task automatic test_identity();
    logic [VW-1:0] vals [16];
    for (int k = 0; k < 16; k++) vals[k] = (k % 5 == 0) ? 32'h0001_0000 : '0;
    send_matrix(vals);
  endtask

  // tiny diagonal entry, inverse out of range both ways
  task automatic test_saturation();
    send_entry(32'h0000_0001, 4'd0, 1'b1);
    send_entry(32'hFFFF_FFFF, 4'd0, 1'b1);
  endtask

  task automatic test_singular();
    send_entry(32'h0000_0000, 4'd5, 1'b1);
  endtask

  task automatic test_extremes();
    send_entry(32'h7FFF_FFFF, 4'd5, 1'b0);
    send_entry(32'h8000_0000, 4'd0, 1'b0);
    send_entry(32'h8000_0000, 4'd15, 1'b1);
  endtask

  function automatic logic [VW-1:0] random_entry(int kind, bit diag);
    case (kind)
      0: return diag ? ($urandom_range(1, 4) << FB) ^ ({VW{$urandom_range(0, 1) == 1}})
                     : $urandom_range(0, 32'hFFFF) - 32'h8000;
      1: return $urandom;
      default: return ($urandom_range(0, 6) - 3) << FB;
    endcase
  endfunction

  task automatic test_random();
    logic [VW-1:0] vals [16];
    int order [16];
    int kind, j, t, n;
    while (entries_sent < RANDOM_ITEMS) begin
      stall_mode = $urandom_range(0, 2);
      kind = $urandom_range(0, 3);
      if (kind == 3) kind = 0;
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 16; k++) begin
          order[k] = k;
          vals[k] = random_entry(kind, k % 5 == 0);
        end
        for (int k = 15; k > 0; k--) begin
          j = $urandom_range(0, k);
          t = order[k]; order[k] = order[j]; order[j] = t;
        end
        for (int k = 0; k < 16; k++)
          send_entry(vals[order[k]], order[k][3:0], k == 15);
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          j = $urandom_range(0, 15);
          send_entry(random_entry(kind, j % 5 == 0), j[3:0], k == n - 1);
        end
      end
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (stall_phase % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    inv_entry_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected", m_tdata[VW-1:0], '0);
        end else begin
          want = inverse_q.pop_front();
          if (m_tdata[VW-1:0] !== want.value)
            report_mismatch("value", m_tdata[VW-1:0], want.value);
          if (m_tdata[VW+3:VW] !== want.index)
            report_mismatch("index", m_tdata[VW+3:VW], want.index);
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
          if (m_tuser[0] !== want.singular)
            report_mismatch("singular", m_tuser[0], want.singular);
          if (m_tuser[1] !== want.saturated)
            report_mismatch("saturated", m_tuser[1], want.saturated);
        end
        results_seen++;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_identity();
    test_saturation();
    test_singular();
    test_extremes();
    test_random();
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (inverse_q.size() != 0) begin
      $display("%0d results never arrived", inverse_q.size());
      error_count++;
    end
    $display("sent %0d entries, %0d inversions (%0d singular)",
             entries_sent, inversions, singular_runs);
    $display("checked %0d results, %0d saturated, %0d errors",
             results_seen, saturated_results, error_count);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
